@@ src/bcc_pkg.sv @@
// Shared types, constants and functions for the CRC-32 / Hamming block check.
// Used by every module under src but bcc_store; depends on nothing else.
`default_nettype none

package bcc_pkg;

   localparam int MAX_BLOCK_BYTES_DEFAULT = 4096;

   localparam int LEN_W     = 13;
   localparam int CRC_W     = 32;
   localparam int ECC_W     = 16;
   localparam int FIXBIT_W  = 15;
   localparam int POS_W     = 17;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 72;

   localparam logic [LEN_W-1:0] BLOCK_BYTES_RESET = 13'd4096;
   localparam logic [CRC_W-1:0] CRC_SEED = 32'hFFFF_FFFF;
   localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;

   localparam logic OP_COMPUTE  = 1'b0;
   localparam logic OP_VALIDATE = 1'b1;

   localparam logic [1:0] STATUS_OK            = 2'd0;
   localparam logic [1:0] STATUS_CORRECTED     = 2'd1;
   localparam logic [1:0] STATUS_UNCORRECTABLE = 2'd2;

   typedef struct packed {
      logic seed;
      logic advance;
   } bcc_crc_ctl_type;

   typedef struct packed {
      logic clear;
      logic advance;
   } bcc_par_ctl_type;

   // One byte of the reflected CRC-32.
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_old,
                                                 input logic [7:0] data);
      logic [CRC_W-1:0] c;
      c = crc_old ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
      end
      return c;
   endfunction

   // Hamming code position of a data bit, given the bit index plus one.
   // The thresholds 2^p - p never decrease, so the number of parity slots
   // skipped is the number of thresholds at or below the index.
   function automatic logic [POS_W-1:0] code_position(input logic [POS_W-1:0] dp1);
      logic [4:0]  k;
      logic [17:0] thr;
      k = '0;
      for (int p = 0; p < 17; p++) begin
         thr = (18'd1 << p) - 18'(p);
         if ({1'b0, dp1} >= thr) begin
            k = k + 5'd1;
         end
      end
      return dp1 + POS_W'(k);
   endfunction

   function automatic logic [3:0] floor_log2(input logic [ECC_W-1:0] v);
      logic [3:0] r;
      r = '0;
      for (int i = 0; i < ECC_W; i++) begin
         if (v[i]) begin
            r = 4'(i);
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ src/bcc_store.sv @@
// Block byte store: one write port, one registered read port.
// Depends on nothing but its parameters.
`default_nettype none

module bcc_store #(
   parameter int DEPTH = 4096,
   parameter int IDX_W = 12
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [IDX_W-1:0] wr_addr,
   input  wire logic [7:0]       wr_data,
   input  wire logic             rd_en,
   input  wire logic [IDX_W-1:0] rd_addr,
   output logic      [7:0]       rd_data
);

   logic [7:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ src/bcc_crc_unit.sv @@
// Shared CRC-32 byte unit with its running register.
// Depends on bcc_pkg for the polynomial, the seed and the control struct.
`default_nettype none

module bcc_crc_unit
   import bcc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire bcc_crc_ctl_type  ctl,
   input  wire logic [7:0]       data,
   output logic      [CRC_W-1:0] crc
);

   logic [CRC_W-1:0] crc_ff;
   logic [CRC_W-1:0] crc_in;

   always_comb begin
      crc_in = crc_ff;
      if (ctl.seed) begin
         crc_in = CRC_SEED;
      end else if (ctl.advance) begin
         crc_in = crc_byte(crc_ff, data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_SEED;
      end else begin
         crc_ff <= crc_in;
      end
   end

   assign crc = crc_ff;

endmodule

`default_nettype wire

@@ src/bcc_parity.sv @@
// Hamming parity accumulator: XORs in the code position of every set bit of a byte.
// Depends on bcc_pkg for code_position and the control struct.
`default_nettype none

module bcc_parity
   import bcc_pkg::*;
#(
   parameter int IDX_W = 12
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire bcc_par_ctl_type  ctl,
   input  wire logic [IDX_W-1:0] idx,
   input  wire logic [7:0]       data,
   output logic      [ECC_W-1:0] parity
);

   logic [ECC_W-1:0] parity_ff;
   logic [ECC_W-1:0] parity_in;
   logic [ECC_W-1:0] term;

   always_comb begin
      logic [POS_W-1:0] dp1;
      logic [POS_W-1:0] pos;
      term = '0;
      for (int k = 0; k < 8; k++) begin
         dp1 = POS_W'({idx, 3'(k)}) + POS_W'(1);
         pos = code_position(dp1);
         if (data[k]) begin
            term = term ^ pos[ECC_W-1:0];
         end
      end
   end

   always_comb begin
      parity_in = parity_ff;
      if (ctl.clear) begin
         parity_in = '0;
      end else if (ctl.advance) begin
         parity_in = parity_ff ^ term;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parity_ff <= '0;
      end else begin
         parity_ff <= parity_in;
      end
   end

   assign parity = parity_ff;

endmodule

`default_nettype wire

@@ src/block_crc32_hamming_check.sv @@
// Top level of the CRC-32 / Hamming block check: sequencer, registers and output stage.
// Depends on bcc_pkg, bcc_store, bcc_crc_unit and bcc_parity.
//
// Usage. Bytes of a block arrive on the req channel, one request per byte, and are
// stored while a reflected CRC-32 and a Hamming parity word are updated. The block
// length comes from the csr port (block_bytes; 0 acts as 1, values above
// MAX_BLOCK_BYTES act as MAX_BLOCK_BYTES). The user must write it only while the
// block is idle; the block does not enforce it. The final byte samples the operation
// and the expected check values, and exactly one response follows on the rsp channel.
// Throughput: one byte per cycle while a block streams in. After the final byte the
// S_DECODE state loads the response register. When a validation fails and the
// syndrome points at a data bit inside the block, the stored block is read back
// through the single read port and run through the one shared CRC byte unit, one
// byte per cycle, and the S_FINISH state then loads the response register.
// req_tready stays low from the final byte until the response register loads.
// Reset (synchronous, active high) empties the response register, seeds the CRC,
// clears the parity and the byte count, and sets block_bytes to 4096. The store has
// no reset and needs no clearing pass: only bytes of the current block are read.
// Stalls: a waiting response is held steady until rsp_tready. Non-final bytes of the
// next block are still taken meanwhile; its final byte waits until the slot is free.
`default_nettype none

module block_crc32_hamming_check
   import bcc_pkg::*;
#(
   parameter int MAX_BLOCK_BYTES = MAX_BLOCK_BYTES_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request channel. tdata, low bit up: data_byte[7:0], expected_crc[39:8],
   // expected_ecc[55:40]. tuser: operation.
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tuser,
   // Response channel. tdata, low bit up: crc_value[31:0], ecc_value[47:32],
   // check_status[49:48], fix_applied[50], fix_bit[65:51], zero pad[71:66].
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   // Configuration: block_bytes.
   input  wire logic                  csr_wr_en,
   input  wire logic [LEN_W-1:0]      csr_wr_data
);

   localparam int CNT_W = $clog2(MAX_BLOCK_BYTES + 1);
   localparam int IDX_W = (MAX_BLOCK_BYTES > 1) ? $clog2(MAX_BLOCK_BYTES) : 1;
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_BLOCK_BYTES);

   typedef enum logic [1:0] {
      S_ACCUM,
      S_DECODE,
      S_SCAN,
      S_FINISH
   } state_type;

   // Request fields.
   logic [7:0]       req_byte;
   logic [CRC_W-1:0] req_exp_crc;
   logic [ECC_W-1:0] req_exp_ecc;

   assign req_byte    = req_tdata[7:0];
   assign req_exp_crc = req_tdata[39:8];
   assign req_exp_ecc = req_tdata[55:40];

   // Registers.
   state_type         state_ff, state_in;
   logic [LEN_W-1:0]  block_bytes_ff, block_bytes_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              op_ff, op_in;
   logic [CRC_W-1:0]  exp_crc_ff, exp_crc_in;
   logic [ECC_W-1:0]  exp_ecc_ff, exp_ecc_in;
   logic [CNT_W-1:0]  received_ff, received_in;
   logic [IDX_W-1:0]  fix_byte_ff, fix_byte_in;
   logic [7:0]        fix_mask_ff, fix_mask_in;
   logic [FIXBIT_W-1:0] fix_bit_ff, fix_bit_in;
   logic [ECC_W-1:0]  par_hold_ff, par_hold_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic              rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CRC_W-1:0]  rsp_crc_ff, rsp_crc_in;
   logic [ECC_W-1:0]  rsp_ecc_ff, rsp_ecc_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic              rsp_applied_ff, rsp_applied_in;
   logic [FIXBIT_W-1:0] rsp_fix_bit_ff, rsp_fix_bit_in;

   // Datapath signals.
   logic [LEN_W-1:0]  len_eff;
   logic [CNT_W-1:0]  count_p1;
   logic              is_final;
   logic              req_accept;
   logic [CRC_W-1:0]  crc_q;
   logic [ECC_W-1:0]  parity_q;
   logic [7:0]        rd_data;
   logic              rd_en;
   logic [7:0]        crc_data;
   bcc_crc_ctl_type   crc_ctl;
   bcc_par_ctl_type   par_ctl;
   logic [ECC_W-1:0]  syndrome;
   logic [ECC_W-1:0]  dbit;
   logic              flip_ok;

   // Effective block length after clamping.
   always_comb begin
      len_eff = block_bytes_ff;
      if (block_bytes_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (block_bytes_ff > MAX_LEN) begin
         len_eff = MAX_LEN;
      end
   end

   assign count_p1   = count_ff + CNT_W'(1);
   assign is_final   = LEN_W'(count_p1) >= len_eff;
   assign req_tready = (state_ff == S_ACCUM) && !(rsp_valid_ff && is_final);
   assign req_accept = req_tvalid && req_tready;

   // Syndrome decode. A syndrome that is zero names no bit, a single bit names a parity
   // position; otherwise the data bit is the position less the parity slots below it.
   assign syndrome = parity_q ^ exp_ecc_ff;
   assign dbit     = syndrome - ECC_W'(2) - ECC_W'(floor_log2(syndrome));
   assign flip_ok  = (syndrome != '0)
                     && ((syndrome & (syndrome - ECC_W'(1))) != '0)
                     && ({1'b0, dbit} < 17'({received_ff, 3'b000}));

   assign rd_en    = (state_ff == S_SCAN) && (scan_ff < received_ff);
   assign crc_data = (state_ff == S_ACCUM) ? req_byte
                   : (rd_data ^ ((rd_idx_ff == fix_byte_ff) ? fix_mask_ff : 8'd0));

   always_comb begin
      state_in       = state_ff;
      block_bytes_in = csr_wr_en ? csr_wr_data : block_bytes_ff;
      count_in       = count_ff;
      op_in          = op_ff;
      exp_crc_in     = exp_crc_ff;
      exp_ecc_in     = exp_ecc_ff;
      received_in    = received_ff;
      fix_byte_in    = fix_byte_ff;
      fix_mask_in    = fix_mask_ff;
      fix_bit_in     = fix_bit_ff;
      par_hold_in    = par_hold_ff;
      scan_in        = scan_ff;
      rd_pend_in     = 1'b0;
      rd_idx_in      = rd_idx_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_crc_in     = rsp_crc_ff;
      rsp_ecc_in     = rsp_ecc_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_applied_in = rsp_applied_ff;
      rsp_fix_bit_in = rsp_fix_bit_ff;
      crc_ctl        = '0;
      par_ctl        = '0;

      case (state_ff)
         S_ACCUM: begin
            if (req_accept) begin
               crc_ctl.advance = 1'b1;
               par_ctl.advance = 1'b1;
               if (is_final) begin
                  count_in    = '0;
                  received_in = count_p1;
                  op_in       = req_tuser;
                  exp_crc_in  = req_exp_crc;
                  exp_ecc_in  = req_exp_ecc;
                  state_in    = S_DECODE;
               end else begin
                  count_in = count_p1;
               end
            end
         end

         S_DECODE: begin
            // The CRC and parity registers now hold the whole block.
            crc_ctl.seed  = 1'b1;
            par_ctl.clear = 1'b1;
            par_hold_in   = parity_q;
            if (op_ff == OP_VALIDATE && crc_q != exp_crc_ff && flip_ok) begin
               fix_byte_in = dbit[IDX_W+2:3];
               fix_mask_in = 8'd1 << dbit[2:0];
               fix_bit_in  = dbit[FIXBIT_W-1:0];
               scan_in     = '0;
               state_in    = S_SCAN;
            end else begin
               rsp_valid_in   = 1'b1;
               rsp_crc_in     = crc_q;
               rsp_ecc_in     = parity_q;
               rsp_applied_in = 1'b0;
               rsp_fix_bit_in = '0;
               rsp_status_in  = (op_ff == OP_VALIDATE && crc_q != exp_crc_ff)
                              ? STATUS_UNCORRECTABLE : STATUS_OK;
               state_in       = S_ACCUM;
            end
         end

         S_SCAN: begin
            if (rd_en) begin
               scan_in    = scan_ff + CNT_W'(1);
               rd_pend_in = 1'b1;
               rd_idx_in  = scan_ff[IDX_W-1:0];
            end
            if (rd_pend_ff) begin
               crc_ctl.advance = 1'b1;
               if (CNT_W'(rd_idx_ff) == received_ff - CNT_W'(1)) begin
                  state_in = S_FINISH;
               end
            end
         end

         S_FINISH: begin
            crc_ctl.seed   = 1'b1;
            rsp_valid_in   = 1'b1;
            rsp_crc_in     = crc_q;
            rsp_ecc_in     = par_hold_ff;
            rsp_applied_in = 1'b1;
            rsp_fix_bit_in = fix_bit_ff;
            rsp_status_in  = (crc_q == exp_crc_ff) ? STATUS_CORRECTED : STATUS_UNCORRECTABLE;
            state_in       = S_ACCUM;
         end

         default: begin
            state_in = S_ACCUM;
         end
      endcase
   end

   // State, control and response registers. The data registers need no reset:
   // each is loaded before it is used.
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      exp_crc_ff     <= exp_crc_in;
      exp_ecc_ff     <= exp_ecc_in;
      received_ff    <= received_in;
      fix_byte_ff    <= fix_byte_in;
      fix_mask_ff    <= fix_mask_in;
      fix_bit_ff     <= fix_bit_in;
      par_hold_ff    <= par_hold_in;
      scan_ff        <= scan_in;
      rd_idx_ff      <= rd_idx_in;
      rsp_crc_ff     <= rsp_crc_in;
      rsp_ecc_ff     <= rsp_ecc_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_applied_ff <= rsp_applied_in;
      rsp_fix_bit_ff <= rsp_fix_bit_in;
      if (reset) begin
         state_ff       <= S_ACCUM;
         block_bytes_ff <= BLOCK_BYTES_RESET;
         count_ff       <= '0;
         rd_pend_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         block_bytes_ff <= block_bytes_in;
         count_ff       <= count_in;
         rd_pend_ff     <= rd_pend_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   bcc_store #(
      .DEPTH (MAX_BLOCK_BYTES),
      .IDX_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (req_accept),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_byte),
      .rd_en   (rd_en),
      .rd_addr (scan_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   bcc_crc_unit u_crc (
      .clock (clock),
      .reset (reset),
      .ctl   (crc_ctl),
      .data  (crc_data),
      .crc   (crc_q)
   );

   bcc_parity #(
      .IDX_W (IDX_W)
   ) u_par (
      .clock  (clock),
      .reset  (reset),
      .ctl    (par_ctl),
      .idx    (count_ff[IDX_W-1:0]),
      .data   (req_byte),
      .parity (parity_q)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_fix_bit_ff, rsp_applied_ff, rsp_status_ff,
                        rsp_ecc_ff, rsp_crc_ff};

endmodule

`default_nettype wire

@@ src/bcc_checker.sv @@
// Port-level checks for block_crc32_hamming_check, bound to the top level.
// Depends on bcc_pkg for field widths and status codes.
`default_nettype none

module bcc_checker
   import bcc_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   // A response held back by the receiver stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // No response comes out of reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // Without a flip the reported bit index is zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[50] |-> rsp_tdata[65:51] == '0)
      else $error("fix_bit set without a flip");

   // A corrected status always comes with a flip; status is never the unused code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[49:48] == STATUS_OK
                      || rsp_tdata[49:48] == STATUS_UNCORRECTABLE
                      || (rsp_tdata[49:48] == STATUS_CORRECTED && rsp_tdata[50])))
      else $error("inconsistent check status");

endmodule

bind block_crc32_hamming_check bcc_checker u_bcc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for block_crc32_hamming_check: it streams byte requests,
// predicts CRC-32, Hamming parity and correction status, and checks every response.
// Depends on bcc_pkg and block_crc32_hamming_check.

module testbench;
   import bcc_pkg::*;

   localparam int MAX_BYTES   = MAX_BLOCK_BYTES_DEFAULT;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int RANDOM_ITEMS = 1030;

   // One byte request as the driver presents it on the request channel.
   typedef struct {
      logic [7:0]  data;
      logic        op;
      logic [31:0] exp_crc;
      logic [15:0] exp_ecc;
   } byte_request_type;

   // One predicted response for a completed block.
   typedef struct {
      logic [31:0] crc;
      logic [15:0] ecc;
      logic [1:0]  status;
      logic        applied;
      logic [14:0] fixbit;
   } check_result_type;

   // Shapes of the blocks that the stimulus builds.
   typedef enum int {
      KIND_COMPUTE,     // compute mode, expected values are don't-care
      KIND_MATCH,       // validate, CRC matches
      KIND_FIX,         // one bit flipped in transit, expected values from clean data
      KIND_FIX_BAD_CRC, // a correctable bit but the expected CRC is wrong too
      KIND_PARITY_SYN,  // CRC mismatch, syndrome zero or a parity position
      KIND_FAR_SYN,     // CRC mismatch, syndrome names a bit past the block
      KIND_NOISE        // random expected values
   } block_kind_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wr_en = 1'b0;
   logic [LEN_W-1:0]      csr_wr_data = '0;

   // Stimulus queue filled by the sequence below, and the responses still owed.
   byte_request_type byte_requests[$];
   check_result_type expected_checks[$];

   // Predictor copy of the block's state and its length register.
   logic [7:0]  stored_bytes [MAX_BYTES];
   logic [31:0] run_crc = CRC_SEED;
   logic [15:0] run_parity = '0;
   int          run_bytes = 0;
   int          cfg_block_bytes = 4096;

   int  mismatches = 0;
   int  blocks_checked = 0;
   int  corrections_seen = 0;
   int  items_queued = 0;
   int  settings_used = 0;
   int  cycle_count = 0;
   logic calm = 1'b0;

   block_crc32_hamming_check dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),   // data_byte[7:0], expected_crc[39:8], expected_ecc[55:40]
      .req_tuser   (req_tuser),   // operation
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),   // crc[31:0], ecc[47:32], status[49:48], fix[50], bit[65:51]
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 8 ns clock.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Prediction helpers
   // ------------------------------------------------------------------

   // One byte of the reflected CRC-32, least significant bit first.
   function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'h0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // Hamming code position (1-based) of a data bit. Every power of two that the
   // position reaches is a parity slot and pushes the data bit one place further.
   function automatic logic [15:0] hamming_pos(input int bit_index);
      int pos;
      int p;
      pos = bit_index + 1;
      p = 0;
      while ((1 << p) <= pos) begin
         pos++;
         p++;
      end
      return 16'(pos);
   endfunction

   // Parity contribution of one byte at a given byte offset in the block.
   function automatic logic [15:0] byte_parity(input int offset, input logic [7:0] b);
      logic [15:0] acc;
      acc = '0;
      for (int k = 0; k < 8; k++) begin
         if (b[k]) begin
            acc ^= hamming_pos(offset * 8 + k);
         end
      end
      return acc;
   endfunction

   // Data bit that a syndrome names: its position minus the parity slots below it.
   function automatic int syndrome_bit(input logic [15:0] syn);
      int lg;
      lg = 0;
      for (int i = 0; i < 16; i++) begin
         if (syn[i]) begin
            lg = i;
         end
      end
      return int'(syn) - 2 - lg;
   endfunction

   // The length register as the block uses it: 0 means 1, oversize means the maximum.
   function automatic int clamp_len(input int value);
      if (value == 0) begin
         return 1;
      end
      return (value > MAX_BYTES) ? MAX_BYTES : value;
   endfunction

   // Advances the predicted state by one accepted request and, when the block is
   // complete, queues the response the block owes for it.
   task automatic predict_block_check(input byte_request_type r);
      int               len;
      int               idx;
      int               received;
      int               dbit;
      logic [15:0]      syn;
      logic [31:0]      crc;
      check_result_type res;
      len = clamp_len(cfg_block_bytes);
      idx = run_bytes % MAX_BYTES;
      stored_bytes[idx] = r.data;
      run_crc = crc32_step(run_crc, r.data);
      run_parity ^= byte_parity(idx, r.data);
      received = idx + 1;
      run_bytes = received;
      if (received < len) begin
         return;
      end
      crc = run_crc;
      res.ecc = run_parity;
      res.status = STATUS_OK;
      res.applied = 1'b0;
      res.fixbit = '0;
      if (r.op == OP_VALIDATE && crc != r.exp_crc) begin
         syn = run_parity ^ r.exp_ecc;
         // Zero and powers of two point at no data bit, so nothing is flipped.
         if (syn != 0 && $countones(syn) != 1) begin
            dbit = syndrome_bit(syn);
            // A bit past the end of the received block is not touched either.
            if (dbit < received * 8) begin
               stored_bytes[dbit / 8][dbit % 8] ^= 1'b1;
               res.applied = 1'b1;
               res.fixbit = 15'(dbit);
               crc = CRC_SEED;
               for (int k = 0; k < received; k++) begin
                  crc = crc32_step(crc, stored_bytes[k]);
               end
            end
         end
         res.status = (res.applied && crc == r.exp_crc) ? STATUS_CORRECTED
                                                        : STATUS_UNCORRECTABLE;
      end
      res.crc = crc;
      expected_checks.push_back(res);
      run_crc = CRC_SEED;
      run_parity = '0;
      run_bytes = 0;
   endtask

   // ------------------------------------------------------------------
   // Request driver
   // ------------------------------------------------------------------

   // Gap lengths: short gaps most of the time, now and then a long pause.
   function automatic int pick_gap();
      return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
   endfunction

   byte_request_type cur_request;
   int               gap_left = 0;

   // The driver offers the next queued request when the channel is free and any random
   // gap has run out. The predictor runs on the edge at which a request is accepted,
   // so its view of the length register is the one the block has at that moment.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_block_check(cur_request);
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (byte_requests.size() > 0) begin
               cur_request = byte_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {cur_request.exp_ecc, cur_request.exp_crc, cur_request.data};
               req_tuser <= cur_request.op;
               gap_left = (!calm && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Response monitor
   // ------------------------------------------------------------------

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      end
   endtask

   task automatic check_response();
      check_result_type want;
      if (expected_checks.size() == 0) begin
         mismatches++;
         $display("%0t: response with none expected, got %0h", $time, rsp_tdata);
         return;
      end
      want = expected_checks.pop_front();
      check_field("crc_value", want.crc, rsp_tdata[31:0]);
      check_field("ecc_value", 32'(want.ecc), 32'(rsp_tdata[47:32]));
      check_field("check_status", 32'(want.status), 32'(rsp_tdata[49:48]));
      check_field("fix_applied", 32'(want.applied), 32'(rsp_tdata[50]));
      check_field("fix_bit", 32'(want.fixbit), 32'(rsp_tdata[65:51]));
      blocks_checked++;
      if (want.status == STATUS_CORRECTED) begin
         corrections_seen++;
      end
   endtask

   int stall_left = 0;

   // The receiver stalls at random, except during calm stretches.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_response();
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            stall_left = pick_gap() - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Cycle counter: it switches calm stretches (no idling on either side) on and
   // off, and ends a run that hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % 256 == 0) begin
         calm <= ($urandom_range(0, 3) == 0);
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses still owed", cycle_count,
                  expected_checks.size());
         $display("block_crc32_hamming_check test failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------

   task automatic push_byte(input logic [7:0] data, input logic op,
                            input logic [31:0] exp_crc, input logic [15:0] exp_ecc);
      byte_request_type r;
      r.data = data;
      r.op = op;
      r.exp_crc = exp_crc;
      r.exp_ecc = exp_ecc;
      byte_requests.push_back(r);
      items_queued++;
   endtask

   // Waits until every request is accepted and every response has arrived, then
   // lets the block settle for as long as the caller asks.
   task automatic wait_until_idle(input int settle);
      do begin
         @(negedge clock);
      end while (byte_requests.size() != 0 || req_tvalid || expected_checks.size() != 0);
      repeat (settle) @(negedge clock);
   endtask

   task automatic write_block_bytes(input int value);
      wait_until_idle(8);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value[LEN_W-1:0];
      cfg_block_bytes = value & 'h1FFF;
      settings_used++;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Queues one whole block at the current length. fill < 0 gives random bytes.
   // Corruption is made by flipping a bit of the sent data while the expected
   // values stay those of the clean data.
   task automatic queue_block(input block_kind_type kind, input int fill);
      logic [7:0]  data [MAX_BYTES];
      int          len;
      int          b;
      logic [31:0] crc;
      logic [15:0] par;
      logic        op;
      logic [31:0] exp_crc;
      logic [15:0] exp_ecc;
      len = clamp_len(cfg_block_bytes);
      crc = CRC_SEED;
      par = '0;
      for (int k = 0; k < len; k++) begin
         data[k] = (fill < 0) ? 8'($urandom) : 8'(fill);
         crc = crc32_step(crc, data[k]);
         par ^= byte_parity(k, data[k]);
      end
      op = OP_VALIDATE;
      exp_crc = crc;
      exp_ecc = 16'($urandom);
      case (kind)
         KIND_COMPUTE: begin
            op = OP_COMPUTE;
            exp_crc = $urandom;
         end
         KIND_MATCH: begin
         end
         KIND_FIX, KIND_FIX_BAD_CRC: begin
            b = $urandom_range(0, len * 8 - 1);
            data[b / 8][b % 8] ^= 1'b1;
            exp_ecc = par;
            if (kind == KIND_FIX_BAD_CRC) begin
               exp_crc = crc ^ ($urandom | 32'h1);
            end
         end
         KIND_PARITY_SYN: begin
            exp_crc = crc ^ ($urandom | 32'h1);
            exp_ecc = ($urandom_range(0, 16) == 16) ? par : par ^ (16'h1 << $urandom_range(0, 15));
         end
         KIND_FAR_SYN: begin
            exp_crc = crc ^ ($urandom | 32'h1);
            if (len < MAX_BYTES) begin
               exp_ecc = par ^ hamming_pos($urandom_range(len * 8, 32767));
            end
         end
         default: begin
            exp_crc = $urandom;
         end
      endcase
      // Only the final byte's operation and expected values matter; the others
      // carry random values there.
      for (int k = 0; k < len; k++) begin
         if (k == len - 1) begin
            push_byte(data[k], op, exp_crc, exp_ecc);
         end else begin
            push_byte(data[k], 1'($urandom), $urandom, 16'($urandom));
         end
      end
   endtask

   function automatic block_kind_type pick_kind();
      int r;
      r = $urandom_range(0, 99);
      if (r < 25) return KIND_COMPUTE;
      if (r < 40) return KIND_MATCH;
      if (r < 70) return KIND_FIX;
      if (r < 78) return KIND_FIX_BAD_CRC;
      if (r < 86) return KIND_PARITY_SYN;
      if (r < 93) return KIND_FAR_SYN;
      return KIND_NOISE;
   endfunction

   function automatic int pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 0;
      if (r < 20) return 1;
      if (r < 70) return $urandom_range(2, 16);
      if (r < 95) return $urandom_range(17, 64);
      return $urandom_range(65, 200);
   endfunction

   initial begin
      int random_start;
      int blocks;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part: one-byte blocks cover the extremes of the data and the
      // expected values, both operations and every decode outcome.
      write_block_bytes(1);
      queue_block(KIND_COMPUTE, 8'h00);
      queue_block(KIND_COMPUTE, 8'hFF);
      push_byte(8'h00, OP_VALIDATE, 32'h0000_0000, 16'hFFFF);
      push_byte(8'hFF, OP_VALIDATE, 32'hFFFF_FFFF, 16'h0000);
      queue_block(KIND_MATCH, -1);
      queue_block(KIND_FIX, -1);
      queue_block(KIND_FIX_BAD_CRC, -1);
      queue_block(KIND_PARITY_SYN, -1);
      queue_block(KIND_FAR_SYN, -1);
      queue_block(KIND_NOISE, -1);

      // A length of zero behaves as one.
      write_block_bytes(0);
      queue_block(KIND_COMPUTE, -1);
      queue_block(KIND_FIX, -1);

      // Length lowered in the middle of a block: three bytes are in when the
      // length drops to two, so the next byte closes a four-byte block.
      write_block_bytes(6);
      repeat (3) push_byte(8'($urandom), 1'($urandom), $urandom, 16'($urandom));
      write_block_bytes(2);
      push_byte(8'($urandom), OP_VALIDATE, $urandom, 16'($urandom));
      queue_block(KIND_FIX, -1);

      // An oversize register value acts as the largest length: twenty bytes do not
      // end the block, and lowering the length below them closes it on the next byte.
      write_block_bytes(8191);
      repeat (20) push_byte(8'($urandom), 1'($urandom), $urandom, 16'($urandom));
      write_block_bytes(3);
      push_byte(8'($urandom), OP_VALIDATE, $urandom, 16'($urandom));

      // Random part: phases of mostly well-formed blocks at random lengths.
      random_start = items_queued;
      while (items_queued - random_start < RANDOM_ITEMS) begin
         write_block_bytes(pick_length());
         blocks = $urandom_range(4, 12);
         repeat (blocks) begin
            if (items_queued - random_start < RANDOM_ITEMS) begin
               queue_block(pick_kind(), -1);
            end
         end
      end

      wait_until_idle(40);
      $display("%0d byte requests sent over %0d length settings", items_queued, settings_used);
      $display("%0d block responses checked, %0d of them corrected", blocks_checked,
               corrections_seen);
      if (mismatches == 0) begin
         $display("block_crc32_hamming_check test passed");
      end else begin
         $display("block_crc32_hamming_check test failed");
      end
      $finish;
   end

endmodule
